FILE: hdl/fccr_pkg.sv
// Shared types, codes and constants for the FAT32 cluster chain reader.
`default_nettype none
package fccr_pkg;

  localparam int unsigned ClusterW = 28;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 112;
  localparam int unsigned AddrW    = 5;

  localparam logic [ClusterW-1:0] CHAIN_END          = 28'hFFF_FFF8;
  localparam logic [31:0]         FIRST_DATA_CLUSTER = 32'd2;
  localparam logic [3:0]          SEC_LOG2_MIN       = 4'd9;
  localparam logic [3:0]          SEC_LOG2_MAX       = 4'd12;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_ENTRY = 1'b1;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_FAT  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [1:0] END_NONE  = 2'd0;
  localparam logic [1:0] END_ALL   = 2'd1;
  localparam logic [1:0] END_EARLY = 2'd2;

  localparam logic [2:0] REG_PART_LBA  = 3'd0;
  localparam logic [2:0] REG_RESERVED  = 3'd1;
  localparam logic [2:0] REG_FAT_COPY  = 3'd2;
  localparam logic [2:0] REG_FAT_SIZE  = 3'd3;
  localparam logic [2:0] REG_CLUS_LOG2 = 3'd4;
  localparam logic [2:0] REG_SEC_LOG2  = 3'd5;

  typedef struct packed {
    logic [31:0] part_lba;
    logic [15:0] reserved;
    logic [7:0]  fat_copies;
    logic [31:0] fat_size;
    logic [2:0]  clus_log2;
    logic [3:0]  sec_log2;
  } cfg_t;

  typedef struct packed {
    logic                action;
    logic [ClusterW-1:0] first_cluster;
    logic [31:0]         file_length;
    logic [31:0]         entry_word;
  } item_t;

  typedef struct packed {
    logic [ClusterW-1:0] cur_cluster;
    logic [31:0]         bytes_left;
    logic [31:0]         wr_offset;
    logic                busy;
  } state_t;

  typedef struct packed {
    logic [1:0]  request_kind;
    logic [31:0] sector_address;
    logic [7:0]  sector_count;
    logic [19:0] copy_length;
    logic [31:0] dest_offset;
    logic [11:0] entry_byte_offset;
    logic [1:0]  end_code;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/fccr_cfg_regs.sv
// Configuration register file with its APB write and read port.
`default_nettype none
module fccr_cfg_regs (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire [fccr_pkg::AddrW-1:0] paddr,
  input  wire [31:0]               pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output fccr_pkg::cfg_t           cfg_o,
  output logic [31:0]              data_off_o
);
  import fccr_pkg::*;

  cfg_t        cfg_q;
  logic [31:0] data_off_q;
  logic [31:0] data_off_d;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.part_lba   <= 32'd0;
      cfg_q.reserved   <= 16'd32;
      cfg_q.fat_copies <= 8'd2;
      cfg_q.fat_size   <= 32'd1;
      cfg_q.clus_log2  <= 3'd3;
      cfg_q.sec_log2   <= 4'd9;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PART_LBA:  cfg_q.part_lba   <= pwdata;
        REG_RESERVED:  cfg_q.reserved   <= pwdata[15:0];
        REG_FAT_COPY:  cfg_q.fat_copies <= pwdata[7:0];
        REG_FAT_SIZE:  cfg_q.fat_size   <= pwdata;
        REG_CLUS_LOG2: cfg_q.clus_log2  <= pwdata[2:0];
        REG_SEC_LOG2:  cfg_q.sec_log2   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Sectors from the partition start to the first data sector, registered
  // from the configuration registers.
  assign data_off_d = {16'd0, cfg_q.reserved}
                    + 32'({24'd0, cfg_q.fat_copies} * cfg_q.fat_size);

  always_ff @(posedge clk_i) begin
    data_off_q <= data_off_d;
  end

  always_comb begin
    case (reg_idx)
      REG_PART_LBA:  prdata = cfg_q.part_lba;
      REG_RESERVED:  prdata = {16'd0, cfg_q.reserved};
      REG_FAT_COPY:  prdata = {24'd0, cfg_q.fat_copies};
      REG_FAT_SIZE:  prdata = cfg_q.fat_size;
      REG_CLUS_LOG2: prdata = {29'd0, cfg_q.clus_log2};
      REG_SEC_LOG2:  prdata = {28'd0, cfg_q.sec_log2};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o      = cfg_q;
  assign data_off_o = data_off_q;

endmodule
`default_nettype wire

FILE: hdl/fccr_step.sv
// Single-pass update of the chain walk for one request and its results.
`default_nettype none
module fccr_step (
  input  fccr_pkg::cfg_t    cfg_i,
  input  wire [31:0]        data_off_i,
  input  fccr_pkg::item_t   item_i,
  input  fccr_pkg::state_t  state_i,
  output fccr_pkg::state_t  state_o,
  output logic [1:0]        res_cnt_o,
  output fccr_pkg::result_t res0_o,
  output fccr_pkg::result_t res1_o
);
  import fccr_pkg::*;

  logic                is_start;
  logic [ClusterW-1:0] cur;
  logic [31:0]         bl;
  logic [31:0]         wo;
  logic [3:0]          slog;
  logic [4:0]          cb_log2;
  logic [19:0]         cl_bytes;
  logic [31:0]         copy;
  logic [31:0]         bl_next;
  logic [31:0]         wo_next;
  logic [31:0]         fat_start;
  logic [31:0]         data_lba;
  logic [31:0]         ebyte;
  logic [31:0]         fat_lba;
  logic [12:0]         sec_mask;
  logic [11:0]         eoff;

  assign is_start = (item_i.action == ACT_START);
  assign cur      = is_start ? item_i.first_cluster : item_i.entry_word[ClusterW-1:0];
  assign bl       = is_start ? item_i.file_length : state_i.bytes_left;
  assign wo       = is_start ? 32'd0 : state_i.wr_offset;

  always_comb begin
    if (cfg_i.sec_log2 inside {[SEC_LOG2_MIN:SEC_LOG2_MAX]}) begin
      slog = cfg_i.sec_log2;
    end else if (cfg_i.sec_log2 < SEC_LOG2_MIN) begin
      slog = SEC_LOG2_MIN;
    end else begin
      slog = SEC_LOG2_MAX;
    end
  end

  assign cb_log2   = {2'd0, cfg_i.clus_log2} + {1'b0, slog};
  assign cl_bytes  = 20'd1 << cb_log2;
  assign copy      = (bl < {12'd0, cl_bytes}) ? bl : {12'd0, cl_bytes};
  assign bl_next   = bl - copy;
  assign wo_next   = wo + copy;
  assign fat_start = cfg_i.part_lba + {16'd0, cfg_i.reserved};
  assign data_lba  = cfg_i.part_lba + data_off_i
                   + (({4'd0, cur} - FIRST_DATA_CLUSTER) << cfg_i.clus_log2);
  assign ebyte     = {2'd0, cur, 2'd0};
  assign fat_lba   = fat_start + (ebyte >> slog);
  assign sec_mask  = (13'd1 << slog) - 13'd1;
  assign eoff      = ebyte[11:0] & sec_mask[11:0];

  always_comb begin
    state_o   = state_i;
    res_cnt_o = 2'd0;
    res0_o    = '0;
    res1_o    = '0;
    if (is_start || state_i.busy) begin
      state_o.cur_cluster = cur;
      if (cur >= CHAIN_END) begin
        res0_o.request_kind = KIND_DONE;
        res0_o.dest_offset  = wo;
        res0_o.end_code     = (is_start && bl != 32'd0) || !is_start ? END_EARLY : END_ALL;
        res0_o.last         = 1'b1;
        res_cnt_o           = 2'd1;
        state_o.bytes_left  = bl;
        state_o.wr_offset   = wo;
        state_o.busy        = 1'b0;
      end else begin
        res0_o.request_kind   = KIND_DATA;
        res0_o.sector_address = data_lba;
        res0_o.sector_count   = 8'd1 << cfg_i.clus_log2;
        res0_o.copy_length    = copy[19:0];
        res0_o.dest_offset    = wo;
        res0_o.end_code       = END_NONE;
        res_cnt_o             = 2'd2;
        state_o.bytes_left    = bl_next;
        state_o.wr_offset     = wo_next;
        res1_o.last           = 1'b1;
        if (bl_next == 32'd0) begin
          res1_o.request_kind = KIND_DONE;
          res1_o.dest_offset  = wo_next;
          res1_o.end_code     = END_ALL;
          state_o.busy        = 1'b0;
        end else begin
          res1_o.request_kind      = KIND_FAT;
          res1_o.sector_address    = fat_lba;
          res1_o.sector_count      = 8'd1;
          res1_o.entry_byte_offset = eoff;
          res1_o.end_code          = END_NONE;
          state_o.busy             = 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/fccr_out_buf.sv
// Two-entry result register that holds the requests of one input item.
`default_nettype none
module fccr_out_buf (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  wire [1:0]         push_cnt_i,
  input  fccr_pkg::result_t res0_i,
  input  fccr_pkg::result_t res1_i,
  output logic              can_push_o,
  output logic              valid_o,
  input  wire               ready_i,
  output fccr_pkg::result_t res_o
);
  import fccr_pkg::*;

  result_t    slot0_q;
  result_t    slot1_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o    = (cnt_q != 2'd0);
  assign pop        = valid_o && ready_i;
  assign can_push_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign res_o      = slot0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (push_i) begin
      cnt_q <= push_cnt_i;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot0_q <= res0_i;
      slot1_q <= res1_i;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/fat32_cluster_chain_reader_core.sv
// Top level of the FAT32 cluster chain reader.
//
//   Port group   Direction  Carries
//   s_axis_*     in         start requests and returned FAT entry words
//   m_axis_*     out        data read, FAT read and done requests
//   APB          in/out     volume geometry registers
//
// An accepted request is registered and processed by a combinational step;
// its one or two results (none for an entry word with no walk busy) land in
// a two-entry output register, and the next request is processed once that
// register has room. Requests that cause one result sustain one per cycle
// while the output is ready; those that cause two hold off the next request
// until the second result leaves. Reset clears the walk state and registers
// to their defaults; a stall on the output holds the pending results, and a
// registered request waits until the last of them leaves, holding the input.
`default_nettype none
module fat32_cluster_chain_reader_core (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // first_cluster[27:0], file_length[59:28], entry_word[91:60], zero pad
  input  wire [fccr_pkg::InDataW-1:0] s_axis_tdata_i,
  // action[0]
  input  wire                       s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  wire                       m_axis_tready_i,
  // sector_address[31:0], sector_count[39:32], copy_length[59:40],
  // dest_offset[91:60], entry_byte_offset[103:92], end_code[105:104], zero pad
  output logic [fccr_pkg::OutDataW-1:0] m_axis_tdata_o,
  // request_kind[1:0]
  output logic [1:0]                m_axis_tuser_o,
  output logic                      m_axis_tlast_o,
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire [fccr_pkg::AddrW-1:0] paddr,
  input  wire [31:0]                pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import fccr_pkg::*;

  cfg_t        cfg;
  logic [31:0] data_off;
  item_t       item_q;
  logic        in_valid_q;
  state_t      state_q;
  state_t      state_d;
  logic [1:0]  res_cnt;
  result_t     res0;
  result_t     res1;
  result_t     res_out;
  logic        can_push;
  logic        fire;

  fccr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg_o      (cfg),
    .data_off_o (data_off)
  );

  assign fire            = in_valid_q && can_push;
  assign s_axis_tready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      item_q.action        <= s_axis_tuser_i;
      item_q.first_cluster <= s_axis_tdata_i[27:0];
      item_q.file_length   <= s_axis_tdata_i[59:28];
      item_q.entry_word    <= s_axis_tdata_i[91:60];
    end
  end

  fccr_step u_step (
    .cfg_i      (cfg),
    .data_off_i (data_off),
    .item_i     (item_q),
    .state_i    (state_q),
    .state_o    (state_d),
    .res_cnt_o  (res_cnt),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  fccr_out_buf u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fire),
    .push_cnt_i (res_cnt),
    .res0_i     (res0),
    .res1_i     (res1),
    .can_push_o (can_push),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .res_o      (res_out)
  );

  assign m_axis_tdata_o = {6'd0, res_out.end_code, res_out.entry_byte_offset,
                           res_out.dest_offset, res_out.copy_length,
                           res_out.sector_count, res_out.sector_address};
  assign m_axis_tuser_o = res_out.request_kind;
  assign m_axis_tlast_o = res_out.last;

endmodule
`default_nettype wire

FILE: tb/sv/fat32_cluster_chain_reader_core_tb.sv
// Self-checking testbench for the FAT32 cluster chain reader core.
`timescale 1ns / 100ps
module fat32_cluster_chain_reader_core_tb;
  import fccr_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 100;

  localparam cfg_t GEOM_DEFAULT = '{32'd0, 16'd32, 8'd2, 32'd1, 3'd3, 4'd9};
  localparam cfg_t GEOM_MIN     = '{32'd0, 16'd1, 8'd1, 32'd1, 3'd0, 4'd9};
  localparam cfg_t GEOM_MAX     = '{32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 3'd7, 4'd12};

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                s_axis_tuser_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;
  logic                m_axis_tlast_o;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [AddrW-1:0]    paddr           = '0;
  logic [31:0]         pwdata          = '0;
  logic [31:0]         prdata;
  logic                pready;

  cfg_t    geometry = GEOM_DEFAULT;
  state_t  walk     = '0;
  result_t expected_requests[$];
  result_t seen_req;
  result_t want_req;

  int gap_pct       = 0;
  int stall_pct     = 0;
  int error_count   = 0;
  int results_seen  = 0;
  int starts_sent   = 0;
  int entries_sent  = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;

  fat32_cluster_chain_reader_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTS) begin
      $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
               results_seen, what, got, want);
    end
    error_count++;
  endtask

  function automatic logic [3:0] sector_shift();
    if (geometry.sec_log2 < SEC_LOG2_MIN) return SEC_LOG2_MIN;
    if (geometry.sec_log2 > SEC_LOG2_MAX) return SEC_LOG2_MAX;
    return geometry.sec_log2;
  endfunction

  function automatic logic [31:0] bytes_per_cluster();
    int shift_amt;
    shift_amt = int'(geometry.clus_log2) + int'(sector_shift());
    return 32'd1 << shift_amt;
  endfunction

  function automatic void finish_walk(input logic [1:0] code);
    result_t r;
    r              = '0;
    r.request_kind = KIND_DONE;
    r.dest_offset  = walk.wr_offset;
    r.end_code     = code;
    r.last         = 1'b1;
    expected_requests.push_back(r);
    walk.busy = 1'b0;
  endfunction

  function automatic void visit_cluster();
    result_t     r;
    logic [31:0] fat_start;
    logic [31:0] data_start;
    logic [31:0] chunk;
    logic [31:0] entry_byte;
    logic [31:0] in_sector;
    int          sshift;
    int          cshift;
    sshift     = int'(sector_shift());
    cshift     = int'(geometry.clus_log2);
    fat_start  = geometry.part_lba + {16'b0, geometry.reserved};
    data_start = fat_start + {24'b0, geometry.fat_copies} * geometry.fat_size;
    chunk      = (walk.bytes_left < bytes_per_cluster()) ? walk.bytes_left
                                                         : bytes_per_cluster();

    r                = '0;
    r.request_kind   = KIND_DATA;
    r.sector_address = data_start + (({4'b0, walk.cur_cluster} - FIRST_DATA_CLUSTER) << cshift);
    r.sector_count   = 8'd1 << cshift;
    r.copy_length    = chunk[19:0];
    r.dest_offset    = walk.wr_offset;
    r.end_code       = END_NONE;
    expected_requests.push_back(r);
    walk.bytes_left = walk.bytes_left - chunk;
    walk.wr_offset  = walk.wr_offset + chunk;
    if (walk.bytes_left == 32'd0) begin
      finish_walk(END_ALL);
      return;
    end

    entry_byte          = {4'b0, walk.cur_cluster} << 2;
    in_sector           = entry_byte & ((32'd1 << sshift) - 32'd1);
    r                   = '0;
    r.request_kind      = KIND_FAT;
    r.sector_address    = fat_start + (entry_byte >> sshift);
    r.sector_count      = 8'd1;
    r.entry_byte_offset = in_sector[11:0];
    r.end_code          = END_NONE;
    r.last              = 1'b1;
    expected_requests.push_back(r);
    walk.busy = 1'b1;
  endfunction

  function automatic void predict_chain_step(input item_t req);
    if (req.action == ACT_START) begin
      walk.cur_cluster = req.first_cluster;
      walk.bytes_left  = req.file_length;
      walk.wr_offset   = 32'd0;
      walk.busy        = 1'b1;
      if (walk.cur_cluster >= CHAIN_END) begin
        finish_walk((walk.bytes_left == 32'd0) ? END_ALL : END_EARLY);
      end else begin
        visit_cluster();
      end
    end else if (walk.busy) begin
      walk.cur_cluster = req.entry_word[ClusterW-1:0];
      if (walk.cur_cluster >= CHAIN_END) begin
        finish_walk(END_EARLY);
      end else begin
        visit_cluster();
      end
    end
  endfunction

  task automatic send_item(input logic act, input logic [27:0] cluster,
                           input logic [31:0] length, input logic [31:0] word);
    item_t req;
    req.action        = act;
    req.first_cluster = cluster;
    req.file_length   = length;
    req.entry_word    = word;
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, req.entry_word, req.file_length, req.first_cluster};
    s_axis_tuser_i  <= req.action;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_chain_step(req);
    if (act == ACT_START) starts_sent++;
    else entries_sent++;
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid_i <= 1'b0;
    while (expected_requests.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PART_LBA:  geometry.part_lba   = value;
      REG_RESERVED:  geometry.reserved   = value[15:0];
      REG_FAT_COPY:  geometry.fat_copies = value[7:0];
      REG_FAT_SIZE:  geometry.fat_size   = value;
      REG_CLUS_LOG2: geometry.clus_log2  = value[2:0];
      REG_SEC_LOG2:  geometry.sec_log2   = value[3:0];
      default: ;
    endcase
  endtask

  task automatic check_register(input logic [2:0] idx, input logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) report_mismatch("register readback", got, want);
  endtask

  task automatic write_geometry(input cfg_t g);
    write_reg(REG_PART_LBA, g.part_lba);
    write_reg(REG_RESERVED, {16'b0, g.reserved});
    write_reg(REG_FAT_COPY, {24'b0, g.fat_copies});
    write_reg(REG_FAT_SIZE, g.fat_size);
    write_reg(REG_CLUS_LOG2, {29'b0, g.clus_log2});
    write_reg(REG_SEC_LOG2, {28'b0, g.sec_log2});
    settings_used++;
  endtask

  task automatic check_geometry(input cfg_t g);
    check_register(REG_PART_LBA, g.part_lba);
    check_register(REG_RESERVED, {16'b0, g.reserved});
    check_register(REG_FAT_COPY, {24'b0, g.fat_copies});
    check_register(REG_FAT_SIZE, g.fat_size);
    check_register(REG_CLUS_LOG2, {29'b0, g.clus_log2});
    check_register(REG_SEC_LOG2, {28'b0, g.sec_log2});
  endtask

  function automatic cfg_t random_geometry();
    cfg_t        g;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    a            = $urandom;
    b            = $urandom;
    c            = $urandom;
    g.part_lba   = $urandom;
    g.reserved   = (a[15:0] == 16'd0) ? 16'd1 : a[15:0];
    g.fat_copies = (b[7:0] == 8'd0) ? 8'd1 : b[7:0];
    g.fat_size   = a[31] ? {22'b0, c[9:0]} + 32'd1 : ((c == 32'd0) ? 32'd1 : c);
    d            = $urandom_range(7);
    g.clus_log2  = d[2:0];
    d            = $urandom_range(12, 9);
    g.sec_log2   = d[3:0];
    return g;
  endfunction

  task automatic test_register_access();
    check_geometry(GEOM_DEFAULT);
    write_geometry(GEOM_MAX);
    check_geometry(GEOM_MAX);
    write_geometry(GEOM_MIN);
    check_geometry(GEOM_MIN);
    write_geometry(GEOM_DEFAULT);
  endtask

  task automatic test_directed_cases();
    gap_pct   = 0;
    stall_pct = 0;
    send_item(ACT_START, 28'hFFF_FFF8, 32'd0, 32'h0);
    send_item(ACT_START, 28'hFFF_FFFF, 32'd100, 32'hFFFF_FFFF);
    send_item(ACT_START, 28'd2, 32'd0, 32'h0);
    send_item(ACT_START, 28'd5, 32'd4096, 32'h0);
    send_item(ACT_START, 28'hFFF_FFF7, 32'hFFFF_FFFF, 32'h0);
    send_item(ACT_ENTRY, 28'h0, 32'h0, 32'h0000_0000);
    send_item(ACT_ENTRY, 28'h0, 32'h0, 32'h0000_0001);
    send_item(ACT_ENTRY, 28'h0, 32'h0, 32'h0FFF_FFF7);
    send_item(ACT_ENTRY, 28'h0, 32'h0, 32'hF000_0003);
    send_item(ACT_ENTRY, 28'h0, 32'h0, 32'h0FFF_FFF8);
    send_item(ACT_ENTRY, 28'h0, 32'h0, 32'h0001_2345);
    send_item(ACT_START, 28'd3, 32'd10000, 32'h0);
    send_item(ACT_START, 28'd7, 32'd5000, 32'h0);
    send_item(ACT_ENTRY, 28'h0, 32'h0, 32'd9);
    send_item(ACT_ENTRY, 28'hFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_START, 28'd0, 32'd1, 32'h0);
    hold_until_drained();
    // Sector size codes outside 512..4096 bytes are clamped by the block.
    write_reg(REG_CLUS_LOG2, 32'd7);
    write_reg(REG_SEC_LOG2, 32'd3);
    settings_used++;
    send_item(ACT_START, 28'd100, 32'd70000, 32'h0);
    send_item(ACT_ENTRY, 28'h0, 32'h0, 32'hFFFF_FFFF);
    hold_until_drained();
    write_reg(REG_SEC_LOG2, 32'd15);
    settings_used++;
    send_item(ACT_START, 28'd1000, 32'h0010_0000, 32'h0);
    send_item(ACT_ENTRY, 28'h0, 32'h0, 32'd2000);
    hold_until_drained();
    write_geometry(GEOM_DEFAULT);
  endtask

  task automatic test_random_walks(input int gap, input int stall, input int n_items,
                                   input cfg_t g);
    int          done_items;
    bit          paused;
    logic [31:0] r;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [27:0] cluster;
    logic [31:0] length;
    logic [31:0] word;
    hold_until_drained();
    write_geometry(g);
    gap_pct    = gap;
    stall_pct  = stall;
    done_items = 0;
    paused     = 1'b0;
    while (done_items < n_items) begin
      if (!paused && done_items == n_items / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
      r = $urandom_range(99);
      a = $urandom;
      b = $urandom;
      c = $urandom;
      if (walk.busy && r < 88) begin
        r = $urandom_range(99);
        if (r < 6) begin
          word = {c[31:28], CHAIN_END | {25'b0, c[2:0]}};
        end else if (r < 12) begin
          word = c;
        end else if (r < 16) begin
          word = {c[31:28], (c[0] ? 28'hFFF_FFF7 : {27'b0, c[1]})};
        end else begin
          d    = $urandom_range(28'hFFF_FFF7);
          word = {c[31:28], d[27:0]};
        end
        send_item(ACT_ENTRY, a[27:0], b, word);
        done_items++;
      end else if (!walk.busy && r < 5) begin
        send_item(ACT_ENTRY, a[27:0], b, c);
      end else begin
        r = $urandom_range(99);
        if (r < 8) cluster = CHAIN_END | {25'b0, a[2:0]};
        else if (r < 20) cluster = {24'b0, a[3:0]};
        else cluster = a[27:0];
        r = $urandom_range(99);
        if (r < 8) length = 32'd0;
        else if (r < 18) length = b;
        else length = $urandom_range(6 * bytes_per_cluster());
        send_item(ACT_START, cluster, length, c);
        done_items++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen_req.request_kind      = m_axis_tuser_o;
      seen_req.sector_address    = m_axis_tdata_o[31:0];
      seen_req.sector_count      = m_axis_tdata_o[39:32];
      seen_req.copy_length       = m_axis_tdata_o[59:40];
      seen_req.dest_offset       = m_axis_tdata_o[91:60];
      seen_req.entry_byte_offset = m_axis_tdata_o[103:92];
      seen_req.end_code          = m_axis_tdata_o[105:104];
      seen_req.last              = m_axis_tlast_o;
      if (expected_requests.size() == 0) begin
        report_mismatch("request with nothing expected", 32'(seen_req.request_kind),
                        32'd0);
      end else begin
        want_req = expected_requests.pop_front();
        if (seen_req.request_kind !== want_req.request_kind)
          report_mismatch("request_kind", 32'(seen_req.request_kind),
                          32'(want_req.request_kind));
        if (seen_req.sector_address !== want_req.sector_address)
          report_mismatch("sector_address", seen_req.sector_address, want_req.sector_address);
        if (seen_req.sector_count !== want_req.sector_count)
          report_mismatch("sector_count", 32'(seen_req.sector_count),
                          32'(want_req.sector_count));
        if (seen_req.copy_length !== want_req.copy_length)
          report_mismatch("copy_length", 32'(seen_req.copy_length),
                          32'(want_req.copy_length));
        if (seen_req.dest_offset !== want_req.dest_offset)
          report_mismatch("dest_offset", seen_req.dest_offset, want_req.dest_offset);
        if (seen_req.entry_byte_offset !== want_req.entry_byte_offset)
          report_mismatch("entry_byte_offset", 32'(seen_req.entry_byte_offset),
                          32'(want_req.entry_byte_offset));
        if (seen_req.end_code !== want_req.end_code)
          report_mismatch("end_code", 32'(seen_req.end_code), 32'(want_req.end_code));
        if (seen_req.last !== want_req.last)
          report_mismatch("last", 32'(seen_req.last), 32'(want_req.last));
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d requests outstanding", expected_requests.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_access();
    test_directed_cases();
    test_random_walks(0, 0, 182, random_geometry());
    test_random_walks(63, 0, 182, GEOM_MIN);
    test_random_walks(0, 63, 182, GEOM_MAX);
    test_random_walks(28, 28, 182, random_geometry());
    hold_until_drained();
    if (expected_requests.size() != 0)
      report_mismatch("requests never produced", 32'(expected_requests.size()), 32'd0);
    $display("Sent %0d file starts and %0d FAT entry words, checked %0d output requests.",
             starts_sent, entries_sent, results_seen);
    $display("Used %0d volume geometries under four sender and receiver stall mixes.",
             settings_used);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: fat32_cluster_chain_reader_core.f
hdl/fccr_pkg.sv
hdl/fccr_cfg_regs.sv
hdl/fccr_step.sv
hdl/fccr_out_buf.sv
hdl/fat32_cluster_chain_reader_core.sv
tb/sv/fat32_cluster_chain_reader_core_tb.sv
